>>> hw/rtl/gkg_pkg.sv
// ----------------------------------------------------------------------------
// gkg_pkg
// Shared types and constants of the gaussian kernel generator.
// ----------------------------------------------------------------------------
package gkg_pkg;

  localparam int MAX_TAPS   = 64;
  localparam int HALF_DEPTH = 32;
  localparam int HALF_AW    = $clog2(HALF_DEPTH);
  localparam int WEIGHT_W   = 24;

  localparam int DIV_NUM_W  = 42;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [28:0] EXP_M1_Q30  = 29'd395007542;
  localparam logic [61:0] HALF_Q30    = 62'h2000_0000;
  localparam logic [41:0] EXP_CUTOFF  = 42'd18 << 16;
  localparam logic [31:0] ONE_Q24     = 32'h0100_0000;
  // ceil(2^21 / 20), exact floor division for numerators below 2^16
  localparam logic [30:0] SIG_RECIP   = 31'd104858;
  localparam logic [6:0]  MAX_TAPS_V  = 7'(MAX_TAPS);
  localparam logic [2:0]  TAYLOR_LAST = 3'd6;
  localparam logic [1:0]  SQUARE_LAST = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SIG_DIV,
    OP_SIG_TAKE,
    OP_S2_MUL,
    OP_S2_TAKE,
    OP_EXP_DIV,
    OP_EXP_TAKE,
    OP_TERM_MUL,
    OP_TERM_DIV,
    OP_TERM_TAKE,
    OP_SQ_MUL,
    OP_SQ_TAKE,
    OP_EM_MUL,
    OP_EM_TAKE,
    OP_WRITE,
    OP_TOTAL,
    OP_READ,
    OP_COEF_DIV,
    OP_COEF_TAKE,
    OP_NEXT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SIG,
    S_SIG_WAIT,
    S_S2_MUL,
    S_S2_TAKE,
    S_EXP_CHECK,
    S_EXP_WAIT,
    S_TMUL,
    S_TDIV,
    S_TWAIT,
    S_SQMUL,
    S_SQTAKE,
    S_EMCHK,
    S_EMTAKE,
    S_WRITE,
    S_RD,
    S_CSTART,
    S_CWAIT,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } gkg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic in_n_zero;
    logic sigma_zero;
    logic exp_more;
    logic exp_cut;
    logic k_last;
    logic sq_last;
    logic m_nonzero;
    logic tap_more;
    logic out_taken;
  } gkg_stat_t;

endpackage

>>> hw/rtl/gaussian_kernel_generator_core.sv
// ----------------------------------------------------------------------------
// gaussian_kernel_generator_core
// Builds a normalized symmetric gaussian kernel for one request.
// ----------------------------------------------------------------------------
// A request enters on the s_axis channel: sigma in unsigned Q8.8 (zero picks
// sigma from the tap count) and a tap count, saturated to 64. The block answers
// on the m_axis channel with one item per tap, in tap order, tlast on the last.
// A zero tap count is accepted and gives no items.
// One request is processed at a time; s_axis_tready is high only while idle.
// Divisions by sigma^2 and by the weight total run through one
// radix-2 divider; constant divisions use reciprocal multiplies. Each outer
// weight runs a Taylor series, repeated squaring and one exp(-1) multiply per
// unit of the integer exponent m (<= 17), all skipped when it is cut off;
// each coefficient waits for m_axis_tready before the next is computed.
// The output register holds its item while m_axis_tready is low and the
// sequencer waits; nothing is lost. Reset returns the sequencer to idle and
// drops any item in flight. Weight memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module gaussian_kernel_generator_core
  import gkg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sigma_q8_8[15:0], tap_count[22:16], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // coefficient[15:0], tap_index[21:16], zero
  output logic        m_axis_tlast
);

  gkg_cmd_t  cmd;
  gkg_stat_t stat;

  gkg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gkg_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> hw/rtl/gkg_ram.sv
// ----------------------------------------------------------------------------
// gkg_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module gkg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/gkg_div.sv
// ----------------------------------------------------------------------------
// gkg_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gkg_div
  import gkg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo,
  output logic                 done
);

  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where numerator bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      if (!diff[DIV_DEN_W]) begin
        rem <= diff[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/gkg_datapath.sv
// ----------------------------------------------------------------------------
// gkg_datapath
// Registers, multiplier, shared divider and weight memory of the generator.
// ----------------------------------------------------------------------------
module gkg_datapath
  import gkg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  gkg_cmd_t  cmd,
  output gkg_stat_t stat,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic [15:0] sigma;
  logic [31:0] s2;
  logic [6:0]  n;
  logic [6:0]  i;
  logic [31:0] total;
  logic        cut;
  logic [4:0]  m;
  logic [26:0] z;
  logic [30:0] acc;
  logic [30:0] term;
  logic [2:0]  k;
  logic [1:0]  sq_cnt;
  logic [61:0] prod;
  logic [30:0] mul_a;
  logic [30:0] mul_b;
  logic [61:0] rnd_sum;
  logic [30:0] rnd;
  logic [30:0] k_recip;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_q;
  logic                 div_done;

  logic [6:0]  in_n;
  logic [4:0]  half;
  logic [6:0]  ax_full;
  logic [11:0] ax2;
  logic [6:0]  mirror;
  logic [6:0]  upper;
  logic        center;
  logic [7:0]  sig_base;
  logic [31:0] q_sum;
  logic [WEIGHT_W-1:0] w_new;
  logic [WEIGHT_W-1:0] ram_rdata;
  logic [24:0] w_sel;
  logic [HALF_AW-1:0]  raddr;

  assign in_n     = (s_axis_tdata[22:16] > MAX_TAPS_V) ? MAX_TAPS_V : s_axis_tdata[22:16];
  assign half     = 5'((n - 7'd1) >> 1);
  assign ax_full  = n - 7'd1 - {i[5:0], 1'b0};
  assign ax2      = {6'd0, ax_full[5:0]} * {6'd0, ax_full[5:0]};
  assign mirror   = n - 7'd1 - i;
  assign upper    = n - {2'd0, half};
  assign center   = (i >= {2'd0, half}) && (i < upper);
  assign sig_base = {1'b0, n} * 8'd3 + 8'd7;
  assign rnd_sum  = prod + HALF_Q30;
  assign rnd      = rnd_sum[60:30];
  assign q_sum    = {1'b0, acc} + 32'd32;
  assign w_new    = cut ? '0 : ((q_sum[31:30] != 2'd0) ? '1 : q_sum[29:6]);
  assign w_sel    = center ? ONE_Q24[24:0] : {1'b0, ram_rdata};
  assign raddr    = (i < {2'd0, half}) ? i[HALF_AW-1:0] : mirror[HALF_AW-1:0];

  // ceil(2^30 / k), exact floor division of taylor terms below 2^27
  always_comb begin
    unique case (k)
      3'd1:    k_recip = 31'h4000_0000;
      3'd2:    k_recip = 31'h2000_0000;
      3'd3:    k_recip = 31'd357913942;
      3'd4:    k_recip = 31'h1000_0000;
      3'd5:    k_recip = 31'd214748365;
      3'd6:    k_recip = 31'd178956971;
      default: k_recip = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SIG_DIV:  begin mul_a = {15'd0, sig_base, 8'd10}; mul_b = SIG_RECIP; end
      OP_S2_MUL:   begin mul_a = {15'd0, sigma}; mul_b = {15'd0, sigma}; end
      OP_TERM_MUL: begin mul_a = term;           mul_b = {4'd0, z};      end
      OP_TERM_DIV: begin mul_a = prod[60:30];    mul_b = k_recip;        end
      OP_SQ_MUL:   begin mul_a = acc;            mul_b = acc;            end
      OP_EM_MUL:   begin mul_a = acc;            mul_b = {2'd0, EXP_M1_Q30}; end
      default:     begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      OP_EXP_DIV: begin
        div_num = {1'b0, ax2, 29'd0} + {11'd0, s2[31:1]};
        div_den = s2;
      end
      OP_COEF_DIV: begin
        div_num = {1'b0, w_sel, 16'd0} + {11'd0, total[31:1]};
        div_den = total;
      end
      default: div_start = 1'b0;
    endcase
  end

  gkg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  gkg_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (HALF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE),
    .waddr (i[HALF_AW-1:0]),
    .wdata (w_new),
    .re    (cmd.op == OP_READ),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    prod <= {31'd0, mul_a} * {31'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        sigma <= s_axis_tdata[15:0];
        n     <= in_n;
        i     <= '0;
        total <= '0;
      end
      OP_SIG_TAKE: sigma <= prod[36:21];
      OP_S2_TAKE:  s2    <= prod[31:0];
      OP_EXP_TAKE: begin
        cut    <= (div_q >= EXP_CUTOFF);
        m      <= div_q[20:16];
        z      <= {div_q[15:0], 11'd0};
        acc    <= ONE_Q30;
        term   <= ONE_Q30;
        k      <= 3'd1;
        sq_cnt <= '0;
      end
      OP_TERM_TAKE: begin
        term <= prod[60:30];
        acc  <= k[0] ? (acc - prod[60:30]) : (acc + prod[60:30]);
        k    <= k + 3'd1;
      end
      OP_SQ_TAKE: begin
        acc    <= rnd;
        sq_cnt <= sq_cnt + 2'd1;
      end
      OP_EM_TAKE: begin
        acc <= rnd;
        m   <= m - 5'd1;
      end
      OP_WRITE: begin
        total <= total + {8'd0, w_new};
        i     <= i + 7'd1;
      end
      OP_TOTAL: begin
        total <= {total[30:0], 1'b0} + (n[0] ? ONE_Q24 : {ONE_Q24[30:0], 1'b0});
        i     <= '0;
      end
      OP_NEXT: i <= i + 7'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.op == OP_COEF_TAKE) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COEF_TAKE) begin
      m_axis_tdata[15:0]  <= (div_q > 42'd65535) ? 16'hFFFF : div_q[15:0];
      m_axis_tdata[21:16] <= i[5:0];
      m_axis_tdata[23:22] <= 2'd0;
      m_axis_tlast        <= (i == n - 7'd1);
    end
  end

  always_comb begin
    stat.div_done   = div_done;
    stat.in_n_zero  = (s_axis_tdata[22:16] == 7'd0);
    stat.sigma_zero = (sigma == 16'd0);
    stat.exp_more   = (i < {2'd0, half});
    stat.exp_cut    = (div_q >= EXP_CUTOFF);
    stat.k_last     = (k == TAYLOR_LAST);
    stat.sq_last    = (sq_cnt == SQUARE_LAST);
    stat.m_nonzero  = (m != 5'd0);
    stat.tap_more   = (i < n);
    stat.out_taken  = m_axis_tvalid && m_axis_tready;
  end

endmodule

>>> hw/rtl/gkg_ctrl.sv
// ----------------------------------------------------------------------------
// gkg_ctrl
// Sequencer that steps the datapath through weight and coefficient phases.
// ----------------------------------------------------------------------------
module gkg_ctrl
  import gkg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  gkg_stat_t stat,
  output gkg_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // a zero tap count is taken and dropped
        if (in_valid && !stat.in_n_zero) begin
          cmd.op     = OP_LOAD;
          state_next = S_SIG;
        end
      end
      S_SIG: begin
        if (stat.sigma_zero) begin
          cmd.op     = OP_SIG_DIV;
          state_next = S_SIG_WAIT;
        end else begin
          state_next = S_S2_MUL;
        end
      end
      S_SIG_WAIT: begin
        cmd.op     = OP_SIG_TAKE;
        state_next = S_S2_MUL;
      end
      S_S2_MUL: begin
        cmd.op     = OP_S2_MUL;
        state_next = S_S2_TAKE;
      end
      S_S2_TAKE: begin
        cmd.op     = OP_S2_TAKE;
        state_next = S_EXP_CHECK;
      end
      S_EXP_CHECK: begin
        if (stat.exp_more) begin
          cmd.op     = OP_EXP_DIV;
          state_next = S_EXP_WAIT;
        end else begin
          cmd.op     = OP_TOTAL;
          state_next = S_RD;
        end
      end
      S_EXP_WAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_EXP_TAKE;
          state_next = stat.exp_cut ? S_WRITE : S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.op     = OP_TERM_MUL;
        state_next = S_TDIV;
      end
      S_TDIV: begin
        cmd.op     = OP_TERM_DIV;
        state_next = S_TWAIT;
      end
      S_TWAIT: begin
        cmd.op     = OP_TERM_TAKE;
        state_next = stat.k_last ? S_SQMUL : S_TMUL;
      end
      S_SQMUL: begin
        cmd.op     = OP_SQ_MUL;
        state_next = S_SQTAKE;
      end
      S_SQTAKE: begin
        cmd.op     = OP_SQ_TAKE;
        state_next = stat.sq_last ? S_EMCHK : S_SQMUL;
      end
      S_EMCHK: begin
        if (stat.m_nonzero) begin
          cmd.op     = OP_EM_MUL;
          state_next = S_EMTAKE;
        end else begin
          cmd.op     = OP_WRITE;
          state_next = S_EXP_CHECK;
        end
      end
      S_EMTAKE: begin
        cmd.op     = OP_EM_TAKE;
        state_next = S_EMCHK;
      end
      S_WRITE: begin
        cmd.op     = OP_WRITE;
        state_next = S_EXP_CHECK;
      end
      S_RD: begin
        if (stat.tap_more) begin
          cmd.op     = OP_READ;
          state_next = S_CSTART;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CSTART: begin
        cmd.op     = OP_COEF_DIV;
        state_next = S_CWAIT;
      end
      S_CWAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_COEF_TAKE;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_taken) begin
          cmd.op     = OP_NEXT;
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/gkg_checker.sv
// ----------------------------------------------------------------------------
// gkg_checker
// Port level checks of the kernel generator, bound to the top level.
// ----------------------------------------------------------------------------
module gkg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // no new request while a coefficient is pending
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while output pending");

  // the highest tap index only occurs on a full kernel's last item
  a_top_index_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[21:16] == 6'd63 |-> m_axis_tlast)
    else $error("tap 63 not marked last");

  // after the last item the block goes quiet
  a_quiet_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("item after last tap");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind gaussian_kernel_generator_core gkg_checker u_gkg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> tb/tb_gaussian_kernel_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gaussian_kernel_generator_core
// Self-checking bench for the gaussian kernel generator.
// Requests (sigma, tap count) go in on s_axis; an internal fixed-point model
// builds the expected taps, and each m_axis item is compared against the
// oldest pending tap. Directed corners come first, then random requests with
// random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_gaussian_kernel_generator_core
  import gkg_pkg::*;
();

  typedef struct packed {
    logic [15:0] sigma;
    logic [6:0]  taps;
  } kreq_t;

  typedef struct packed {
    logic [15:0] coef;
    logic [5:0]  idx;
    logic        last;
  } ktap_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  ktap_t       pending_taps[$];
  logic [23:0] outer_w[HALF_DEPTH];
  logic [31:0] kernel_total;
  int          fail_count;
  int          tap_count_seen;
  int          req_count;
  bit          hold_rx;
  bit          stim_done;

  gaussian_kernel_generator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // sigma_q8_8[15:0], tap_count[22:16], zero
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // coefficient[15:0], tap_index[21:16], zero
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // exp(-e) for e in Q16, result in Q0.24
  function automatic logic [23:0] gauss_weight(input logic [63:0] e_q16);
    logic [63:0] z, term, s;
    longint      acc;
    int          m;
    logic [63:0] q;
    if (e_q16 >= 64'(EXP_CUTOFF)) return 24'd0;
    m    = int'(e_q16 >> 16);
    z    = (e_q16 & 64'hFFFF) << 11;
    acc  = longint'(ONE_Q30);
    term = 64'(ONE_Q30);
    for (int k = 1; k <= 6; k++) begin
      term = ((term * z) >> 30) / k;
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    s = 64'(acc);
    for (int k = 0; k < 3; k++) s = (s * s + 64'(HALF_Q30)) >> 30;
    for (int k = 0; k < m; k++) s = (s * 64'(EXP_M1_Q30) + 64'(HALF_Q30)) >> 30;
    q = (s + 64'd32) >> 6;
    if (q > 64'hFF_FFFF) q = 64'hFF_FFFF;
    return q[23:0];
  endfunction

  // queue the taps a request produces; zero taps leaves state untouched
  task automatic build_kernel(input kreq_t rq);
    int          n, half;
    logic [63:0] s, s2, ax, tot, w, c;
    ktap_t       t;
    n = rq.taps;
    if (n == 0) return;
    if (n > MAX_TAPS) n = MAX_TAPS;
    s = rq.sigma;
    if (s == 0) s = ((3 * n + 7) * 256 + 10) / 20;
    s2   = s * s;
    half = (n - 1) / 2;
    tot  = 0;
    for (int i = 0; i < half; i++) begin
      ax = n - 1 - 2 * i;
      outer_w[i] = gauss_weight((((ax * ax) << 29) + (s2 >> 1)) / s2);
      tot += outer_w[i];
    end
    tot = tot * 2 + ((n % 2 == 1) ? 64'(ONE_Q24) : 2 * 64'(ONE_Q24));
    kernel_total = tot[31:0];
    for (int i = 0; i < n; i++) begin
      if (i < half) w = outer_w[i];
      else if (i >= n - half) w = outer_w[n - 1 - i];
      else w = 64'(ONE_Q24);
      c = (w * 65536 + (64'(kernel_total) >> 1)) / 64'(kernel_total);
      if (c > 65535) c = 65535;
      t.coef = c[15:0];
      t.idx  = 6'(i);
      t.last = (i == n - 1);
      pending_taps.push_back(t);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid drops between requests
  task automatic send_req(input kreq_t rq);
    int g;
    g = gap_len();
    repeat (g + 1) @(negedge clk);
    s_axis_tdata  <= {1'b0, rq.taps, rq.sigma};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    build_kernel(rq);
    req_count++;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_taps.size() != 0) @(negedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off while hold_rx is set
  initial begin
    int g;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx) m_axis_tready <= 1'b0;
      else begin
        g = gap_len();
        if (g > 0 && $urandom_range(0, 3) == 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    ktap_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.coef = m_axis_tdata[15:0];
      got.idx  = m_axis_tdata[21:16];
      got.last = m_axis_tlast;
      tap_count_seen++;
      if (pending_taps.size() == 0) begin
        $error("unexpected coefficient item %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_taps.pop_front();
        if (got.coef !== want.coef) begin
          $error("coefficient: expected %0d, got %0d", want.coef, got.coef);
          fail_count++;
        end
        if (got.idx !== want.idx) begin
          $error("tap_index: expected %0d, got %0d", want.idx, got.idx);
          fail_count++;
        end
        if (got.last !== want.last) begin
          $error("last_tap: expected %0d, got %0d", want.last, got.last);
          fail_count++;
        end
      end
    end
  end

  // directed requests; exp_first is the typed first coefficient, or -1
  typedef struct {
    logic [15:0] sigma;
    logic [6:0]  taps;
    int          exp_first;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{16'h0000, 7'd1,   65535},   // single tap saturates
    '{16'h0100, 7'd1,   65535},
    '{16'h0000, 7'd0,   -1},      // zero taps, no items
    '{16'h0000, 7'd2,   32768},   // two centre taps
    '{16'hFFFF, 7'd2,   32768},
    '{16'h0000, 7'd3,   -1},
    '{16'h0001, 7'd3,   0},       // tiny sigma, outer weights cut off
    '{16'h0001, 7'd64,  0},
    '{16'hFFFF, 7'd3,   -1},      // huge sigma, outer weights near one
    '{16'h0100, 7'd5,   -1},
    '{16'h0080, 7'd7,   -1},
    '{16'h0000, 7'd64,  -1},
    '{16'h0000, 7'd127, -1},      // count above max saturates
    '{16'h0000, 7'd65,  -1},
    '{16'h0200, 7'd64,  -1},
    '{16'hFFFF, 7'd64,  -1},
    '{16'h5555, 7'd42,  -1},
    '{16'hAAAA, 7'd21,  -1},
    '{16'h0000, 7'd0,   -1},
    '{16'h0300, 7'd4,   -1}
  };

  initial begin
    kreq_t rq;
    int    r;
    int    first_pos;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_rx = 1'b0;
    stim_done = 1'b0;
    fail_count = 0;
    tap_count_seen = 0;
    req_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      rq.sigma = dir_rows[i].sigma;
      rq.taps  = dir_rows[i].taps;
      send_req(rq);
      if (dir_rows[i].exp_first >= 0 && pending_taps.size() != 0) begin
        first_pos = pending_taps.size() - 1 - (rq.taps > 64 ? 63 : rq.taps - 1);
        if (pending_taps[first_pos].coef !== 16'(dir_rows[i].exp_first)) begin
          $error("coefficient: expected %0d, got %0d (model)", dir_rows[i].exp_first,
                 pending_taps[first_pos].coef);
          fail_count++;
        end
      end
      if (i == 4) wait_drained();   // sender pauses until all taps are back
    end

    // long receiver hold-off while requests keep coming
    hold_rx = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_rx = 1'b0;
      end
      for (int j = 0; j < 3; j++) begin
        rq.sigma = 16'($urandom_range(64, 1024));
        rq.taps  = 7'($urandom_range(2, 12));
        send_req(rq);
      end
    join

    // random part: mostly small kernels, a few large and odd ones
    for (int j = 0; j < 200; j++) begin
      r = $urandom_range(0, 99);
      if (r < 15) rq.sigma = 16'd0;
      else if (r < 80) rq.sigma = 16'($urandom_range(16, 1536));
      else rq.sigma = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 75) rq.taps = 7'($urandom_range(1, 12));
      else if (r < 90) rq.taps = 7'($urandom_range(13, 64));
      else if (r < 95) rq.taps = 7'($urandom_range(65, 127));
      else rq.taps = 7'd0;
      send_req(rq);
    end

    wait_drained();
    repeat (200) @(negedge clk);
    $display("requests sent: %0d, coefficient items checked: %0d", req_count,
             tap_count_seen);
    $display("covered auto and explicit sigma, 0..127 taps, long output stalls");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
